[hw/rtl/temp_humidity_compensation_macros.svh]
// Assertion macros for the compensation RTL.
`ifndef TEMP_HUMIDITY_COMPENSATION_MACROS_SVH
`define TEMP_HUMIDITY_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define THC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define THC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/thc_pkg.sv]
package thc_pkg;

   // Pipeline depth of the compensation datapath.
   localparam int unsigned NUM_STAGES = 15;

   // Stream payload widths, padded to whole bytes.
   localparam int unsigned REQ_TDATA_WIDTH = 40;
   localparam int unsigned RSP_TDATA_WIDTH = 88;

   // Configuration port widths.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 24;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TEMP_COEF_ONE      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TEMP_COEF_TWO      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TEMP_COEF_THREE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HUM_COEF_ONE       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HUM_COEF_TWO       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HUM_COEF_THREE     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HUM_COEF_FOUR_FIVE = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HUM_COEF_SIX       = 3'd7;

   // Formula constants.
   localparam logic signed [31:0] TEMP_ROUND    = 32'sd128;
   localparam logic signed [31:0] HUM_FINE_BASE = 32'sd76800;
   localparam logic signed [31:0] HUM_P_ROUND   = 32'sd16384;
   localparam logic signed [31:0] HUM_Q_OFFSET  = 32'sd32768;
   localparam logic signed [31:0] HUM_Q_BIAS    = 32'sd2097152;
   localparam logic signed [31:0] HUM_Q_ROUND   = 32'sd8192;
   localparam logic signed [31:0] HUM_MAX       = 32'sd419430400;

   // Raw register contents as written through the configuration port.
   typedef struct packed {
      logic [15:0] temp_coef_one;
      logic [15:0] temp_coef_two;
      logic [15:0] temp_coef_three;
      logic [7:0]  hum_coef_one;
      logic [15:0] hum_coef_two;
      logic [7:0]  hum_coef_three;
      logic [23:0] hum_coef_four_five;
      logic [7:0]  hum_coef_six;
   } csr_type;

   // Coefficients extended to 32-bit signed operands for the datapath.
   typedef struct packed {
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic signed [31:0] t3;
      logic signed [31:0] h1;
      logic signed [31:0] h2;
      logic signed [31:0] h3;
      logic signed [31:0] h4;
      logic signed [31:0] h5;
      logic signed [31:0] h6;
   } coef_type;

   // Payload carried through every pipeline stage.
   typedef struct packed {
      logic [19:0]        raw_t;
      logic [15:0]        raw_h;
      logic signed [31:0] ta;
      logic signed [31:0] tb;
      logic signed [31:0] fine;
      logic signed [31:0] temp;
      logic signed [31:0] hx;
      logic signed [31:0] hp;
      logic signed [31:0] hq;
      logic signed [31:0] hr;
      logic [16:0]        hum;
   } stage_type;

   // Arithmetic (floor) right shift of a 32-bit two's complement value.
   function automatic logic signed [31:0] asr32(input logic signed [31:0] v,
                                                input int unsigned n);
      return v >>> n;
   endfunction

endpackage

[hw/rtl/thc_pipe.sv]
`include "temp_humidity_compensation_macros.svh"

module thc_pipe (
   input  logic                clock,
   input  logic                reset,
   input  thc_pkg::coef_type   coef,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [19:0]         in_raw_t,
   input  logic [15:0]         in_raw_h,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [31:0]  out_temp,
   output logic signed [31:0]  out_fine,
   output logic [16:0]         out_hum
);

   localparam int unsigned LAST = thc_pkg::NUM_STAGES - 1;

   logic [thc_pkg::NUM_STAGES-1:0] valid_ff;
   logic [thc_pkg::NUM_STAGES-1:0] valid_in;
   logic [thc_pkg::NUM_STAGES:0]   adv;
   thc_pkg::stage_type             st_ff [thc_pkg::NUM_STAGES];
   thc_pkg::stage_type             st_in [thc_pkg::NUM_STAGES];
   logic signed [31:0]             hsum;
   logic signed [31:0]             sq;
   logic signed [31:0]             xc;

   // A stage moves when it is empty or its successor moves.
   always_comb begin
      adv[thc_pkg::NUM_STAGES] = out_ready;
      for (int k = LAST; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   // Valid bits follow the payload.
   always_comb begin
      if (adv[0]) begin
         valid_in[0] = in_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k <= LAST; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   // Stage logic: at most one multiplication per data path in each stage, plus adds and shifts.
   always_comb begin
      // Temperature differences.
      st_in[0]       = '0;
      st_in[0].raw_t = in_raw_t;
      st_in[0].raw_h = in_raw_h;
      st_in[0].ta    = $signed({15'd0, in_raw_t[19:3]}) - (coef.t1 <<< 1);
      st_in[0].tb    = $signed({16'd0, in_raw_t[19:4]}) - coef.t1;

      // Linear and square temperature products.
      st_in[1]    = st_ff[0];
      st_in[1].ta = st_ff[0].ta * coef.t2;
      st_in[1].tb = st_ff[0].tb * st_ff[0].tb;

      // Scale the square term by the third coefficient.
      st_in[2]    = st_ff[1];
      st_in[2].ta = thc_pkg::asr32(st_ff[1].ta, 11);
      st_in[2].tb = thc_pkg::asr32(st_ff[1].tb, 12) * coef.t3;

      // Fine temperature.
      st_in[3]      = st_ff[2];
      st_in[3].fine = st_ff[2].ta + thc_pkg::asr32(st_ff[2].tb, 14);

      // Temperature rounding sum and humidity offset.
      st_in[4]      = st_ff[3];
      st_in[4].temp = (st_ff[3].fine <<< 2) + st_ff[3].fine + thc_pkg::TEMP_ROUND;
      st_in[4].hx   = st_ff[3].fine - thc_pkg::HUM_FINE_BASE;

      // Three humidity products of the offset fine temperature.
      st_in[5]      = st_ff[4];
      st_in[5].temp = thc_pkg::asr32(st_ff[4].temp, 8);
      st_in[5].hp   = coef.h5 * st_ff[4].hx;
      st_in[5].hq   = st_ff[4].hx * coef.h6;
      st_in[5].hr   = st_ff[4].hx * coef.h3;

      // Humidity base term and scaled factors.
      hsum = $signed({2'd0, st_ff[5].raw_h, 14'd0}) - (coef.h4 <<< 20)
           - st_ff[5].hp + thc_pkg::HUM_P_ROUND;
      st_in[6]    = st_ff[5];
      st_in[6].hp = thc_pkg::asr32(hsum, 15);
      st_in[6].hq = thc_pkg::asr32(st_ff[5].hq, 10);
      st_in[6].hr = thc_pkg::asr32(st_ff[5].hr, 11) + thc_pkg::HUM_Q_OFFSET;

      st_in[7]    = st_ff[6];
      st_in[7].hq = st_ff[6].hq * st_ff[6].hr;

      st_in[8]    = st_ff[7];
      st_in[8].hq = thc_pkg::asr32(st_ff[7].hq, 10) + thc_pkg::HUM_Q_BIAS;

      st_in[9]    = st_ff[8];
      st_in[9].hq = st_ff[8].hq * coef.h2;

      st_in[10]    = st_ff[9];
      st_in[10].hq = thc_pkg::asr32(st_ff[9].hq + thc_pkg::HUM_Q_ROUND, 14);

      // Uncorrected humidity.
      st_in[11]    = st_ff[10];
      st_in[11].hx = st_ff[10].hp * st_ff[10].hq;

      // Square of the scaled humidity for the correction term.
      sq           = thc_pkg::asr32(st_ff[11].hx, 15);
      st_in[12]    = st_ff[11];
      st_in[12].hr = sq * sq;

      st_in[13]    = st_ff[12];
      st_in[13].hr = thc_pkg::asr32(st_ff[12].hr, 7) * coef.h1;

      // Correction, clamp and final shift.
      xc = st_ff[13].hx - thc_pkg::asr32(st_ff[13].hr, 4);
      if (xc < 32'sd0) begin
         xc = 32'sd0;
      end else if (xc > thc_pkg::HUM_MAX) begin
         xc = thc_pkg::HUM_MAX;
      end
      st_in[14]     = st_ff[13];
      st_in[14].hum = xc[28:12];
   end

   // Valid bits reset; payload registers load on advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= LAST; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[LAST];
   assign out_temp  = st_ff[LAST].temp;
   assign out_fine  = st_ff[LAST].fine;
   assign out_hum   = st_ff[LAST].hum;

   // An empty first stage always takes a transaction.
   `THC_ASSERT_NOW(a_first_ready, clock, reset, !valid_ff[0], in_ready, "empty first stage not ready")
   // An accepted transaction lands in the first stage.
   `THC_ASSERT_NEXT(a_enter, clock, reset, in_valid && in_ready, valid_ff[0], "transaction lost at entry")
   // A held middle stage keeps its item.
   `THC_ASSERT_NEXT(a_hold, clock, reset, valid_ff[7] && !adv[7], valid_ff[7], "stalled item dropped")
   // Humidity never leaves its clamped range.
   `THC_ASSERT_NOW(a_hum_range, clock, reset, out_valid, out_hum <= 17'd102400, "humidity out of range")

endmodule

[hw/rtl/temp_humidity_compensation.sv]
// Throughput: one reading per cycle while the rsp side is ready. The
// fifteen-stage pipeline has at most one multiply per data path in each
// stage, and a stalled rsp side only holds stages that are full. Reset
// (synchronous, active high) empties the pipeline and clears all
// calibration registers to zero.
module temp_humidity_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: raw_temperature[19:0], raw_humidity[35:20], zero pad [39:36]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [thc_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // rsp_tdata: temperature_centi[31:0], fine_temperature[63:32],
   // humidity_q10[80:64], zero pad [87:81]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [thc_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [thc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [thc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   thc_pkg::csr_type  csr_ff;
   thc_pkg::csr_type  csr_in;
   thc_pkg::coef_type coef;
   logic signed [31:0] out_temp;
   logic signed [31:0] out_fine;
   logic [16:0]        out_hum;

   // Register writes are always accepted.
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            thc_pkg::REG_TEMP_COEF_ONE:      csr_in.temp_coef_one      = csr_data[15:0];
            thc_pkg::REG_TEMP_COEF_TWO:      csr_in.temp_coef_two      = csr_data[15:0];
            thc_pkg::REG_TEMP_COEF_THREE:    csr_in.temp_coef_three    = csr_data[15:0];
            thc_pkg::REG_HUM_COEF_ONE:       csr_in.hum_coef_one       = csr_data[7:0];
            thc_pkg::REG_HUM_COEF_TWO:       csr_in.hum_coef_two       = csr_data[15:0];
            thc_pkg::REG_HUM_COEF_THREE:     csr_in.hum_coef_three     = csr_data[7:0];
            thc_pkg::REG_HUM_COEF_FOUR_FIVE: csr_in.hum_coef_four_five = csr_data;
            thc_pkg::REG_HUM_COEF_SIX:       csr_in.hum_coef_six       = csr_data[7:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Extend the coefficients to 32-bit signed operands.
   always_comb begin
      coef.t1 = $signed({16'd0, csr_ff.temp_coef_one});
      coef.t2 = 32'(signed'(csr_ff.temp_coef_two));
      coef.t3 = 32'(signed'(csr_ff.temp_coef_three));
      coef.h1 = $signed({24'd0, csr_ff.hum_coef_one});
      coef.h2 = 32'(signed'(csr_ff.hum_coef_two));
      coef.h3 = $signed({24'd0, csr_ff.hum_coef_three});
      coef.h4 = 32'(signed'(csr_ff.hum_coef_four_five[11:0]));
      coef.h5 = 32'(signed'(csr_ff.hum_coef_four_five[23:12]));
      coef.h6 = 32'(signed'(csr_ff.hum_coef_six));
   end

   thc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_raw_t  (req_tdata[19:0]),
      .in_raw_h  (req_tdata[35:20]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (out_temp),
      .out_fine  (out_fine),
      .out_hum   (out_hum)
   );

   // Pack the result transaction.
   assign rsp_tdata = {7'd0, out_hum, out_fine, out_temp};

endmodule

[test/temp_humidity_compensation_checker.sv]
// Watches the reading, result and register channels of the compensation block.
// It keeps its own copy of the calibration registers and computes the expected
// result of every accepted reading. It then compares each result transaction
// with the oldest expected result, one field at a time.
module temp_humidity_compensation_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [thc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [thc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [thc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [thc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  results_pending
);

   import thc_pkg::*;

   // Fixed terms of the compensation formulas.
   localparam int FINE_OFFSET     = 76800;
   localparam int HUM_RAW_ROUND   = 16384;
   localparam int HUM_GAIN_OFFSET = 32768;
   localparam int HUM_GAIN_BIAS   = 2097152;
   localparam int HUM_GAIN_ROUND  = 8192;
   localparam int HUM_CEILING     = 419430400;
   localparam int CENTI_ROUND     = 128;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [16:0]        humidity_q10;
   } compensated_type;

   csr_type         calib;
   compensated_type expected_readings[$];

   // Integer compensation of one reading. Every intermediate is a signed
   // 32-bit value that wraps, and every right shift is arithmetic.
   function automatic compensated_type compensate(input logic [19:0] raw_t,
                                                  input logic [15:0] raw_h,
                                                  input csr_type c);
      int t1, t2, t3, h1, h2, h3, h4, h5, h6;
      int adc_t, adc_h, ta, tb, d, fine, x, p, q, v;
      compensated_type r;
      t1 = {16'd0, c.temp_coef_one};
      t2 = $signed(c.temp_coef_two);
      t3 = $signed(c.temp_coef_three);
      h1 = {24'd0, c.hum_coef_one};
      h2 = $signed(c.hum_coef_two);
      h3 = {24'd0, c.hum_coef_three};
      h4 = $signed(c.hum_coef_four_five[11:0]);
      h5 = $signed(c.hum_coef_four_five[23:12]);
      h6 = $signed(c.hum_coef_six);
      adc_t = {12'd0, raw_t};
      adc_h = {16'd0, raw_h};

      // Temperature: a linear term and a squared term give the fine value.
      ta = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc_t >>> 4) - t1;
      tb = (((d * d) >>> 12) * t3) >>> 14;
      fine = ta + tb;
      r.fine_temperature = fine;
      r.temperature_centi = (fine * 5 + CENTI_ROUND) >>> 8;

      // Humidity: offset term times temperature-dependent gain.
      x = fine - FINE_OFFSET;
      p = ((adc_h <<< 14) - (h4 <<< 20) - h5 * x + HUM_RAW_ROUND) >>> 15;
      q = ((x * h6) >>> 10) * (((x * h3) >>> 11) + HUM_GAIN_OFFSET);
      q = (q >>> 10) + HUM_GAIN_BIAS;
      q = (q * h2 + HUM_GAIN_ROUND) >>> 14;
      v = p * q;
      d = v >>> 15;
      v = v - ((((d * d) >>> 7) * h1) >>> 4);

      // Clamp to the valid range before dropping the low bits.
      if (v < 0) begin
         v = 0;
      end
      if (v > HUM_CEILING) begin
         v = HUM_CEILING;
      end
      r.humidity_q10 = 17'(v >>> 12);
      return r;
   endfunction

   // Track register writes, queue predictions and check results.
   always @(posedge clock) begin
      compensated_type want;
      int errs;
      errs = 0;
      if (reset) begin
         calib <= '0;
         expected_readings.delete();
         fail_count <= 0;
         results_pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $error("result transaction with no reading outstanding");
               errs++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata[31:0] !== want.temperature_centi) begin
                  $error("temperature_centi expected %0d actual %0d",
                         want.temperature_centi, $signed(rsp_tdata[31:0]));
                  errs++;
               end
               if (rsp_tdata[63:32] !== want.fine_temperature) begin
                  $error("fine_temperature expected %0d actual %0d",
                         want.fine_temperature, $signed(rsp_tdata[63:32]));
                  errs++;
               end
               if (rsp_tdata[80:64] !== want.humidity_q10) begin
                  $error("humidity_q10 expected %0d actual %0d",
                         want.humidity_q10, rsp_tdata[80:64]);
                  errs++;
               end
               if (rsp_tdata[87:81] !== 7'd0) begin
                  $error("pad expected %0d actual %0d", 0, rsp_tdata[87:81]);
                  errs++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            expected_readings.push_back(compensate(req_tdata[19:0], req_tdata[35:20], calib));
         end

         // Only the low bits of each register survive a write.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TEMP_COEF_ONE:      calib.temp_coef_one <= csr_data[15:0];
               REG_TEMP_COEF_TWO:      calib.temp_coef_two <= csr_data[15:0];
               REG_TEMP_COEF_THREE:    calib.temp_coef_three <= csr_data[15:0];
               REG_HUM_COEF_ONE:       calib.hum_coef_one <= csr_data[7:0];
               REG_HUM_COEF_TWO:       calib.hum_coef_two <= csr_data[15:0];
               REG_HUM_COEF_THREE:     calib.hum_coef_three <= csr_data[7:0];
               REG_HUM_COEF_FOUR_FIVE: calib.hum_coef_four_five <= csr_data[23:0];
               REG_HUM_COEF_SIX:       calib.hum_coef_six <= csr_data[7:0];
               default: ;
            endcase
         end

         fail_count <= fail_count + errs;
         results_pending <= expected_readings.size();
      end
   end

endmodule

[test/temp_humidity_compensation_tb.sv]
// Drives readings and calibration writes into the compensation block and
// stalls its result side. The checker next to the block does all prediction.
module temp_humidity_compensation_tb;

   import thc_pkg::*;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_EVERY_THIRD
   } ready_style_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   int                         failures;
   int                         results_pending;
   int                         hold_requests = 0;

   always #5 clock = ~clock;

   temp_humidity_compensation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   temp_humidity_compensation_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (failures),
      .results_pending (results_pending)
   );

   // Offer one reading and return at the falling edge after its transaction.
   task automatic send_reading(input logic [19:0] raw_t, input logic [15:0] raw_h);
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, raw_h, raw_t};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Write one register with random junk above its width.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input int value,
                            input int width);
      logic [31:0] word;
      word = ($urandom << width) | (value & ((32'd1 << width) - 1));
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= word[23:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_coefs(input int t1, t2, t3, h1, h2, h3, h4, h5, h6);
      write_reg(REG_TEMP_COEF_ONE, t1, 16);
      write_reg(REG_TEMP_COEF_TWO, t2, 16);
      write_reg(REG_TEMP_COEF_THREE, t3, 16);
      write_reg(REG_HUM_COEF_ONE, h1, 8);
      write_reg(REG_HUM_COEF_TWO, h2, 16);
      write_reg(REG_HUM_COEF_THREE, h3, 8);
      write_reg(REG_HUM_COEF_FOUR_FIVE, ((h5 & 'hFFF) << 12) | (h4 & 'hFFF), 24);
      write_reg(REG_HUM_COEF_SIX, h6, 8);
      csr_valid <= 1'b0;
   endtask

   // Stop offering and wait until every reading has come back.
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (NUM_STAGES + 5) @(negedge clock);
   endtask

   function automatic logic [19:0] random_raw_t();
      case ($urandom_range(0, 9))
         0: return 20'd0;
         1: return 20'hFFFFF;
         2, 3: return 20'($urandom_range(400000, 600000));
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_raw_h();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(20000, 40000));
         default: return 16'($urandom);
      endcase
   endfunction

   // Random readings in bursts with random gaps. With long_hold the first
   // burst runs without gaps while the result side is held off.
   task automatic run_readings(input int count, input bit long_hold);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         if (long_hold && sent == 0) begin
            hold_requests++;
            burst = 70;
         end
         for (int i = 0; i < burst && sent < count; i++) begin
            send_reading(random_raw_t(), random_raw_h());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Result side: ready follows a style that changes every so often, and a
   // hold request drops it for a long stretch.
   initial begin
      ready_style_type style;
      int span;
      int hold_left;
      int holds_seen;
      rsp_tready = 1'b0;
      style = READY_ALWAYS;
      span = 0;
      hold_left = 0;
      holds_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left = 80;
         end
         if (span == 0) begin
            style = ready_style_type'($urandom_range(0, 3));
            span = $urandom_range(10, 120);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (style)
               READY_ALWAYS:  rsp_tready <= 1'b1;
               READY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               READY_MOSTLY:  rsp_tready <= ($urandom_range(0, 7) != 0);
               default:       rsp_tready <= (span % 3 == 0);
            endcase
         end
      end
   end

   // Main sequence of calibration phases.
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Calibration still at its reset value of zero.
      send_reading(20'd0, 16'd0);
      send_reading(20'hFFFFF, 16'hFFFF);
      send_reading(20'hAAAAA, 16'h5555);
      send_reading(20'h55555, 16'hAAAA);
      settle_pipeline();

      // Typical calibration: readings near room conditions and the raw extremes.
      program_coefs(27504, 26435, -1000, 75, 362, 0, 313, 50, 30);
      send_reading(20'd0, 16'd0);
      send_reading(20'hFFFFF, 16'hFFFF);
      send_reading(20'd0, 16'hFFFF);
      send_reading(20'hFFFFF, 16'd0);
      send_reading(20'd519888, 16'd0);
      send_reading(20'd519888, 16'hFFFF);
      send_reading(20'd519888, 16'd27000);
      send_reading(20'd519888, 16'd40000);
      send_reading(20'd400000, 16'd27000);
      send_reading(20'd600000, 16'd27000);
      run_readings(300, 1'b1);
      settle_pipeline();

      // Every coefficient at its largest value.
      program_coefs(65535, 32767, 32767, 255, 32767, 255, 2047, 2047, 127);
      send_reading(20'd0, 16'd0);
      send_reading(20'hFFFFF, 16'hFFFF);
      run_readings(150, 1'b0);
      settle_pipeline();

      // Every coefficient at its smallest value.
      program_coefs(0, -32768, -32768, 0, -32768, 0, -2048, -2048, -128);
      send_reading(20'd0, 16'd0);
      send_reading(20'hFFFFF, 16'hFFFF);
      run_readings(150, 1'b0);
      settle_pipeline();

      // Random calibrations, alternating between plausible and arbitrary sets.
      for (int phase = 0; phase < 7; phase++) begin
         if (phase % 2 == 0) begin
            program_coefs($urandom_range(26000, 29000), $urandom_range(25000, 27500),
                          -int'($urandom_range(0, 1200)), $urandom_range(0, 120),
                          $urandom_range(300, 420), $urandom_range(0, 30),
                          $urandom_range(250, 400), $urandom_range(0, 100),
                          $urandom_range(0, 40));
         end else begin
            program_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
         end
         run_readings(190, 1'b0);
         settle_pipeline();
      end

      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[temp_humidity_compensation.f]
+incdir+hw/rtl
hw/rtl/thc_pkg.sv
hw/rtl/thc_pipe.sv
hw/rtl/temp_humidity_compensation.sv
test/temp_humidity_compensation_checker.sv
test/temp_humidity_compensation_tb.sv
